>>> sv/assert_macros.svh
// Assertion macros shared by the slice store RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on a given clock, disabled while reset is high.
`define ASSERT_CLK(label, prop, clk, rst) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check a property on the block clock and reset.
`define ASSERT_SYNC(label, prop) `ASSERT_CLK(label, prop, clock, reset)

`endif

>>> sv/pov_sdb_pkg.sv
// Types, constants and helpers of the rotating-display slice store.
package pov_sdb_pkg;

   localparam int MAX_TOTAL_SLICES = 512;
   localparam int REV_COUNTS       = 4096;
   localparam int ROWS_PER_SLICE   = 32;

   localparam int HALF_REV  = REV_COUNTS / 2;
   localparam int LIN_W     = (MAX_TOTAL_SLICES > 1) ? $clog2(MAX_TOTAL_SLICES) : 1;

   localparam int CMD_W     = 3;
   localparam int KIND_W    = 2;
   localparam int FRAME_W   = 10;
   localparam int SLICE_W   = 13;
   localparam int LEN_W     = 20;
   localparam int ROW_W     = 5;
   localparam int DATA_W    = 16;
   localparam int STATUS_W  = 3;
   localparam int TRIG_W    = 12;

   localparam int ADDR_W    = 1 + LIN_W + ROW_W;
   localparam int PROD_W    = FRAME_W + SLICE_W;
   localparam int BYTE_SH   = $clog2(ROWS_PER_SLICE * 2);
   localparam int LEN_CMP_W = PROD_W + BYTE_SH;

   localparam int QUOT_W    = (HALF_REV > 1) ? $clog2(HALF_REV) : 1;
   localparam int DVD_W     = SLICE_W + QUOT_W;
   localparam int CNT_W     = $clog2(QUOT_W + 1);
   localparam int SUM_W     = (QUOT_W + 1 > TRIG_W) ? QUOT_W + 1 : TRIG_W;

   localparam logic [KIND_W-1:0] KIND_STILL = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ANIM  = 2'd1;

   typedef enum logic [CMD_W-1:0] {
      CMD_BEGIN     = 3'd0,
      CMD_WRITE_ROW = 3'd1,
      CMD_REQ_SWAP  = 3'd2,
      CMD_SWAP_IF   = 3'd3,
      CMD_READ_STEP = 3'd4,
      CMD_CLEAR     = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK            = 3'd0,
      ST_INVALID_ARG   = 3'd1,
      ST_NOT_SUPPORTED = 3'd2,
      ST_INVALID_STATE = 3'd3,
      ST_NO_MEM        = 3'd4
   } status_type;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [KIND_W-1:0]  data_kind;
      logic [FRAME_W-1:0] frames_in;
      logic [SLICE_W-1:0] slices_in;
      logic [LEN_W-1:0]   payload_bytes;
      logic [FRAME_W-1:0] frame_sel;
      logic [SLICE_W-1:0] step_sel;
      logic [ROW_W-1:0]   row_sel;
      logic [DATA_W-1:0]  row_data;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [DATA_W-1:0]  row_out;
      logic [TRIG_W-1:0]  trigger_count;
      logic               mirrored;
      logic               swapped;
      logic               pending_out;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic [DVD_W-1:0]   dividend;
      logic [SLICE_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [QUOT_W-1:0]  quotient;
   } div_rsp_type;

   function automatic logic [DATA_W-1:0] flip16(input logic [DATA_W-1:0] v);
      logic [DATA_W-1:0] r;
      for (int i = 0; i < DATA_W; i++) begin
         r[i] = v[DATA_W-1-i];
      end
      return r;
   endfunction

endpackage

>>> sv/pov_sdb_req_if.sv
// Command channel interface of the slice store.
interface pov_sdb_req_if import pov_sdb_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> sv/pov_sdb_rsp_if.sv
// Result channel interface of the slice store.
interface pov_sdb_rsp_if import pov_sdb_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> sv/pov_slice_double_buffer.sv
// Top level: double-buffered slice store for a rotating display.
// Commands pass through S_MUL and S_EXEC to S_OUT; a valid read_step also waits in S_DIV.
// The 11-step serial divider serves read_step; a new transfer is taken only once S_OUT is left.
// A result waiting on the output register does not block the next transfer in.
// Reset clears bank shapes and valid bits, selects bank A and drops a pending swap.
// The row store is not cleared: rows read before being written return arbitrary data.
module pov_slice_double_buffer import pov_sdb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   pov_sdb_req_if.sink     req_chan,
   pov_sdb_rsp_if.source   rsp_chan
);

`include "assert_macros.svh"

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL  = 5'b00010,
      S_EXEC = 5'b00100,
      S_DIV  = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [SLICE_W-1:0] sl_ff, sl_in;
   logic               mir_ff, mir_in;
   logic [FRAME_W-1:0] frames_ff [2];
   logic [FRAME_W-1:0] frames_in [2];
   logic [SLICE_W-1:0] slices_ff [2];
   logic [SLICE_W-1:0] slices_in [2];
   logic               valid_ff [2];
   logic               valid_in [2];
   logic               active_ff, active_in;
   logic               swap_ff, swap_in;
   rsp_type            res_ff, res_in;
   rsp_type            out_ff, out_in;
   logic               out_valid_ff, out_valid_in;

   cmd_type            cmd;
   logic               sel_bank;
   logic [FRAME_W-1:0] sel_frames;
   logic [SLICE_W-1:0] sel_slices;
   logic               sel_valid;
   logic [FRAME_W-1:0] fr_eff;
   logic [FRAME_W-1:0] mul_a;
   logic [SLICE_W-1:0] mul_b;
   logic               step_ge_n;
   logic [PROD_W:0]    lin_sum;
   logic [LIN_W-1:0]   lin;
   logic               bad_slices;
   logic               len_bad;
   logic               reshape;
   logic [SUM_W-1:0]   trig_sum;

   logic               ram_we;
   logic               ram_re;
   logic [ADDR_W-1:0]  ram_addr;
   logic [DATA_W-1:0]  ram_rdata;

   div_req_type        div_req;
   div_rsp_type        div_rsp;

   pov_sdb_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (DATA_W)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (req_ff.row_data),
      .rdata (ram_rdata)
   );

   pov_sdb_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign cmd        = cmd_type'(req_ff.cmd);
   assign sel_bank   = (cmd == CMD_READ_STEP) ? active_ff : ~active_ff;
   assign sel_frames = frames_ff[sel_bank];
   assign sel_slices = slices_ff[sel_bank];
   assign sel_valid  = valid_ff[sel_bank];

   assign fr_eff    = (req_ff.data_kind == KIND_STILL) ? FRAME_W'(1) : req_ff.frames_in;
   assign mul_a     = (cmd == CMD_BEGIN) ? fr_eff : req_ff.frame_sel;
   assign mul_b     = (cmd == CMD_BEGIN) ? req_ff.slices_in : sel_slices;
   assign step_ge_n = req_ff.step_sel >= sel_slices;

   assign lin_sum = (PROD_W + 1)'(prod_ff) + (PROD_W + 1)'(sl_ff);
   assign lin     = (lin_sum >= (PROD_W + 1)'(MAX_TOTAL_SLICES)) ? '0 : lin_sum[LIN_W-1:0];
   assign ram_addr = {sel_bank, lin, req_ff.row_sel};

   assign bad_slices = (req_ff.slices_in == '0) || (int'(req_ff.slices_in) > REV_COUNTS);
   assign len_bad    = {prod_ff, {BYTE_SH{1'b0}}} != LEN_CMP_W'(req_ff.payload_bytes);
   assign reshape    = !sel_valid || (sel_frames != fr_eff) || (sel_slices != req_ff.slices_in);

   assign trig_sum = SUM_W'(div_rsp.quotient) + (mir_ff ? SUM_W'(HALF_REV) : SUM_W'(0));

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      prod_in      = prod_ff;
      sl_in        = sl_ff;
      mir_in       = mir_ff;
      frames_in    = frames_ff;
      slices_in    = slices_ff;
      valid_in     = valid_ff;
      active_in    = active_ff;
      swap_in      = swap_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = DVD_W'(sl_ff) * DVD_W'(HALF_REV);
      div_req.divisor  = sel_slices;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               req_in   = req_chan.payload;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = PROD_W'(mul_a) * PROD_W'(mul_b);
            mir_in   = (cmd == CMD_READ_STEP) && step_ge_n;
            sl_in    = mir_in ? req_ff.step_sel - sel_slices : req_ff.step_sel;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            res_in        = '0;
            res_in.status = ST_OK;
            state_in      = S_OUT;
            case (cmd)
               CMD_BEGIN: begin
                  if (bad_slices) begin
                     res_in.status = ST_INVALID_ARG;
                  end else if (req_ff.data_kind != KIND_STILL &&
                               req_ff.data_kind != KIND_ANIM) begin
                     res_in.status = ST_NOT_SUPPORTED;
                  end else if (req_ff.data_kind == KIND_ANIM && req_ff.frames_in == '0) begin
                     res_in.status = ST_INVALID_ARG;
                  end else if (len_bad) begin
                     res_in.status = ST_INVALID_ARG;
                  end else if (reshape) begin
                     frames_in[sel_bank] = '0;
                     slices_in[sel_bank] = '0;
                     valid_in[sel_bank]  = 1'b0;
                     if (prod_ff > PROD_W'(MAX_TOTAL_SLICES)) begin
                        res_in.status = ST_NO_MEM;
                     end else begin
                        frames_in[sel_bank] = fr_eff;
                        slices_in[sel_bank] = req_ff.slices_in;
                        valid_in[sel_bank]  = 1'b1;
                     end
                  end
               end
               CMD_WRITE_ROW: begin
                  if (!sel_valid) begin
                     res_in.status = ST_INVALID_STATE;
                  end else if (req_ff.frame_sel >= sel_frames ||
                               req_ff.step_sel >= sel_slices) begin
                     res_in.status = ST_INVALID_ARG;
                  end else begin
                     ram_we = 1'b1;
                  end
               end
               CMD_REQ_SWAP: begin
                  if (!sel_valid) begin
                     res_in.status = ST_INVALID_STATE;
                  end else begin
                     swap_in = 1'b1;
                  end
               end
               CMD_SWAP_IF: begin
                  if (swap_ff) begin
                     active_in      = ~active_ff;
                     swap_in        = 1'b0;
                     res_in.swapped = 1'b1;
                  end
               end
               CMD_READ_STEP: begin
                  if (!sel_valid) begin
                     res_in.status = ST_INVALID_STATE;
                  end else if (req_ff.frame_sel >= sel_frames || sel_slices == '0 ||
                               {1'b0, req_ff.step_sel} >= {sel_slices, 1'b0}) begin
                     res_in.status = ST_INVALID_ARG;
                  end else begin
                     ram_re          = 1'b1;
                     div_req.start   = 1'b1;
                     res_in.mirrored = mir_ff;
                     state_in        = S_DIV;
                  end
               end
               CMD_CLEAR: begin
                  frames_in = '{default: '0};
                  slices_in = '{default: '0};
                  valid_in  = '{default: 1'b0};
                  active_in = 1'b0;
                  swap_in   = 1'b0;
               end
               default: begin
                  res_in.status = ST_INVALID_ARG;
               end
            endcase
            res_in.pending_out = swap_in;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               res_in.row_out       = mir_ff ? flip16(ram_rdata) : ram_rdata;
               res_in.trigger_count = trig_sum[TRIG_W-1:0];
               state_in             = S_OUT;
            end
         end
         S_OUT: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         frames_ff    <= '{default: '0};
         slices_ff    <= '{default: '0};
         valid_ff     <= '{default: 1'b0};
         active_ff    <= 1'b0;
         swap_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         frames_ff    <= frames_in;
         slices_ff    <= slices_in;
         valid_ff     <= valid_in;
         active_ff    <= active_in;
         swap_ff      <= swap_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      prod_ff <= prod_in;
      sl_ff   <= sl_in;
      mir_ff  <= mir_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
   end

   `ASSERT_SYNC(a_swap_clears_pending, out_valid_ff && out_ff.swapped |-> !out_ff.pending_out)
   `ASSERT_SYNC(a_error_zero_fields, out_valid_ff && out_ff.status != ST_OK |->
      out_ff.row_out == '0 && out_ff.trigger_count == '0 && !out_ff.mirrored)
   `ASSERT_SYNC(a_div_only_read, div_req.start |-> cmd == CMD_READ_STEP && state_ff == S_EXEC)

endmodule

>>> sv/pov_sdb_ram.sv
// Single-port synchronous RAM with registered read data.
module pov_sdb_ram #(
   parameter int ADDR_W = 15,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              we,
   input  logic              re,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/pov_sdb_div.sv
// Bit-serial restoring divider for the step trigger count.
module pov_sdb_div import pov_sdb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

`include "assert_macros.svh"

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SLICE_W-1:0] rem_ff, rem_in;
   logic [QUOT_W-1:0]  low_ff, low_in;
   logic [QUOT_W-1:0]  quot_ff, quot_in;
   logic [SLICE_W-1:0] dvs_ff, dvs_in;
   logic [SLICE_W:0]   trial;
   logic [SLICE_W:0]   diff;
   logic               fits;

   assign trial = {rem_ff, low_ff[QUOT_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QUOT_W);
         rem_in  = div_req.dividend[DVD_W-1:QUOT_W];
         low_in  = div_req.dividend[QUOT_W-1:0];
         quot_in = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[SLICE_W-1:0] : trial[SLICE_W-1:0];
         low_in  = low_ff << 1;
         quot_in = (quot_ff << 1) | QUOT_W'(fits);
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      dvs_ff  <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

   `ASSERT_SYNC(a_start_when_idle, div_req.start |-> !busy_ff)
   `ASSERT_SYNC(a_done_ends_run, done_ff |-> $past(busy_ff) && !busy_ff)

endmodule
